@@ src/cffa_pkg.sv @@
package cffa_pkg;

  localparam int IDX_W  = 12;
  localparam int SIZE_W = 15;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } cffa_req_t;

  typedef enum logic {
    STAT_OK  = 1'b0,
    STAT_OOM = 1'b1
  } cffa_stat_t;

  // header word: next header index and busy flag
  typedef struct packed {
    logic [IDX_W-1:0] next;
    logic             busy;
  } cffa_hdr_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FREE_RD,
    S_FREE_WR,
    S_SENT0,
    S_SENT1,
    S_RD_P,
    S_CHK_P,
    S_CHK_Q,
    S_FIT_HDR,
    S_GROW_TOP,
    S_GROW_BASE,
    S_GROW_END,
    S_DONE
  } cffa_state_t;

endpackage

@@ src/cffa_hdr_ram.sv @@
module cffa_hdr_ram #(
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  cffa_pkg::cffa_hdr_t wr_data,
  input  logic [AW-1:0]      rd_addr,
  output cffa_pkg::cffa_hdr_t rd_data
);
  import cffa_pkg::*;

  cffa_hdr_t mem [DEPTH];
  cffa_hdr_t mem_q;
  cffa_hdr_t fwd_data_r;
  logic      fwd_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    mem_q      <= mem[rd_addr];
    // same-cycle write to the address being read: hand back the new word
    fwd_r      <= wr_en && (wr_addr == rd_addr);
    fwd_data_r <= wr_data;
  end

  assign rd_data = fwd_r ? fwd_data_r : mem_q;

endmodule

@@ src/circular_first_fit_allocator.sv @@
// Channel  Direction  Handshake          Payload
// in_      input      in_valid/in_stall  req_type, size_bytes, free_index
// out_     output     out_valid/out_stall data_index, status
//
// A free reads its header and writes it back free (not for a null index), then hands
// off the result. An allocate writes the sentinels on the very first allocate, then visits
// headers, checking and merging free neighbors, splitting a block and growing the arena as
// needed; every step is one access of the header RAM's single read port.
// in_stall is high while an item is at work, including while its result waits on
// out_stall. rst_n is synchronous; the header RAM is not cleared.
module circular_first_fit_allocator #(
  parameter int POOL_WORDS = 4096,
  parameter int GROW_WORDS = 128,
  parameter int WORD_BYTES = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_req_type,
  input  logic [cffa_pkg::SIZE_W-1:0]   in_size_bytes,
  input  logic [cffa_pkg::IDX_W-1:0]    in_free_index,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [cffa_pkg::IDX_W-1:0]    out_data_index,
  output logic                          out_status
);
  import cffa_pkg::*;

  localparam int MEM_DEPTH = (POOL_WORDS < (1 << IDX_W)) ? POOL_WORDS : (1 << IDX_W);
  localparam int AW        = $clog2(MEM_DEPTH);
  localparam int NW_MAX    = ((1 << SIZE_W) - 1 + 2 * WORD_BYTES - 1) / WORD_BYTES;
  localparam int NW_W      = $clog2(NW_MAX + 1);
  localparam int SUM_W     = $clog2(POOL_WORDS + (1 << IDX_W) + NW_MAX + 2 * GROW_WORDS) + 1;

  cffa_state_t state_r, state_nxt;
  logic [IDX_W-1:0] p_r, p_nxt;
  logic [IDX_W-1:0] cur_next_r, cur_next_nxt;
  logic [IDX_W-1:0] np_r, np_nxt;
  logic [IDX_W-1:0] search_r, search_nxt;
  logic [IDX_W-1:0] top_r, top_nxt;
  logic [SUM_W-1:0] brk_r, brk_nxt;
  logic [SUM_W-1:0] gbase_r, gbase_nxt;
  logic [NW_W-1:0]  nw_r, nw_nxt;
  logic             sent_r, sent_nxt;
  logic             pass_r, pass_nxt;
  logic [IDX_W-1:0] res_data_r, res_data_nxt;
  logic             res_stat_r, res_stat_nxt;

  logic             out_valid_r;
  logic [IDX_W-1:0] out_data_r;
  logic             out_stat_r;

  logic [IDX_W-1:0] rd_idx;
  logic             wr_req;
  logic [SUM_W-1:0] wr_addr;
  cffa_hdr_t        wr_data;
  cffa_hdr_t        ram_q;
  cffa_hdr_t        hdr;
  logic             oob_r;

  logic [NW_W-1:0]  nw_calc;
  logic [SUM_W-1:0] p_plus;
  logic [SUM_W-1:0] chunk;
  logic [SUM_W-1:0] nb;
  logic [SUM_W-1:0] q_ext;
  logic             do_adv;
  logic [IDX_W-1:0] adv_pn;

  assign nw_calc = NW_W'((SUM_W'(in_size_bytes) + SUM_W'(2 * WORD_BYTES - 1)) / WORD_BYTES);
  assign p_plus  = SUM_W'(p_r) + SUM_W'(nw_r);
  assign chunk   = SUM_W'(((SUM_W'(nw_r) + SUM_W'(GROW_WORDS)) / GROW_WORDS) * GROW_WORDS);
  assign nb      = brk_r + chunk;
  assign q_ext   = SUM_W'(cur_next_r);

  cffa_hdr_ram #(.DEPTH(MEM_DEPTH)) u_ram (
    .clk     (clk),
    .wr_en   (wr_req && (wr_addr < SUM_W'(MEM_DEPTH))),
    .wr_addr (wr_addr[AW-1:0]),
    .wr_data (wr_data),
    .rd_addr (rd_idx[AW-1:0]),
    .rd_data (ram_q)
  );

  // headers beyond the pool read as zero
  always_ff @(posedge clk) begin
    oob_r <= SUM_W'(rd_idx) >= SUM_W'(POOL_WORDS);
  end

  assign hdr = oob_r ? '0 : ram_q;

  always_comb begin
    state_nxt    = state_r;
    p_nxt        = p_r;
    cur_next_nxt = cur_next_r;
    np_nxt       = np_r;
    search_nxt   = search_r;
    top_nxt      = top_r;
    brk_nxt      = brk_r;
    gbase_nxt    = gbase_r;
    nw_nxt       = nw_r;
    sent_nxt     = sent_r;
    pass_nxt     = pass_r;
    res_data_nxt = res_data_r;
    res_stat_nxt = res_stat_r;
    rd_idx       = p_r;
    wr_req       = 1'b0;
    wr_addr      = SUM_W'(p_r);
    wr_data      = '0;
    do_adv       = 1'b0;
    adv_pn       = cur_next_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          res_data_nxt = '0;
          res_stat_nxt = STAT_OK;
          if (in_req_type == REQ_FREE) begin
            if (in_free_index != '0) begin
              p_nxt      = in_free_index - 1'b1;
              search_nxt = in_free_index - 1'b1;
              state_nxt  = S_FREE_RD;
            end else begin
              state_nxt = S_DONE;
            end
          end else begin
            nw_nxt = nw_calc;
            if (!sent_r) begin
              state_nxt = S_SENT0;
            end else begin
              p_nxt     = search_r;
              state_nxt = S_RD_P;
            end
          end
        end
      end
      S_FREE_RD: begin
        state_nxt = S_FREE_WR;
      end
      S_FREE_WR: begin
        wr_req       = 1'b1;
        wr_data.next = hdr.next;
        wr_data.busy = 1'b0;
        state_nxt    = S_DONE;
      end
      S_SENT0: begin
        wr_req       = 1'b1;
        wr_addr      = '0;
        wr_data.next = IDX_W'(1);
        wr_data.busy = 1'b1;
        state_nxt    = S_SENT1;
      end
      S_SENT1: begin
        wr_req       = 1'b1;
        wr_addr      = SUM_W'(1);
        wr_data.next = '0;
        wr_data.busy = 1'b1;
        top_nxt      = IDX_W'(1);
        search_nxt   = '0;
        sent_nxt     = 1'b1;
        p_nxt        = '0;
        state_nxt    = S_RD_P;
      end
      S_RD_P: begin
        pass_nxt  = 1'b0;
        state_nxt = S_CHK_P;
      end
      S_CHK_P: begin
        if (!hdr.busy) begin
          cur_next_nxt = hdr.next;
          rd_idx       = hdr.next;
          state_nxt    = S_CHK_Q;
        end else begin
          do_adv = 1'b1;
          adv_pn = hdr.next;
        end
      end
      S_CHK_Q: begin
        if (!hdr.busy && (hdr.next > cur_next_r)) begin
          // absorb the free neighbor and look at the one after it
          wr_req       = 1'b1;
          wr_data.next = hdr.next;
          wr_data.busy = 1'b0;
          cur_next_nxt = hdr.next;
          if (cur_next_r == search_r) begin
            search_nxt = hdr.next;
          end
          rd_idx = hdr.next;
        end else if (q_ext >= p_plus) begin
          search_nxt = p_plus[IDX_W-1:0];
          np_nxt     = p_plus[IDX_W-1:0];
          if (q_ext > p_plus) begin
            wr_req       = 1'b1;
            wr_addr      = p_plus;
            wr_data.next = cur_next_r;
            wr_data.busy = 1'b0;
            state_nxt    = S_FIT_HDR;
          end else begin
            wr_req       = 1'b1;
            wr_data.next = p_plus[IDX_W-1:0];
            wr_data.busy = 1'b1;
            res_data_nxt = p_r + 1'b1;
            state_nxt    = S_DONE;
          end
        end else begin
          do_adv = 1'b1;
          adv_pn = cur_next_r;
        end
      end
      S_FIT_HDR: begin
        wr_req       = 1'b1;
        wr_data.next = np_r;
        wr_data.busy = 1'b1;
        res_data_nxt = p_r + 1'b1;
        state_nxt    = S_DONE;
      end
      S_GROW_TOP: begin
        if (nb >= SUM_W'(POOL_WORDS)) begin
          res_stat_nxt = STAT_OOM;
          state_nxt    = S_DONE;
        end else begin
          brk_nxt      = nb;
          gbase_nxt    = brk_r;
          wr_req       = 1'b1;
          wr_addr      = SUM_W'(top_r);
          wr_data.next = brk_r[IDX_W-1:0];
          wr_data.busy = brk_r != (SUM_W'(top_r) + 1'b1);
          top_nxt      = IDX_W'(nb - 1'b1);
          state_nxt    = S_GROW_BASE;
        end
      end
      S_GROW_BASE: begin
        wr_req       = 1'b1;
        wr_addr      = gbase_r;
        wr_data.next = top_r;
        wr_data.busy = 1'b0;
        state_nxt    = S_GROW_END;
      end
      S_GROW_END: begin
        wr_req       = 1'b1;
        wr_addr      = SUM_W'(top_r);
        wr_data.next = '0;
        wr_data.busy = 1'b1;
        state_nxt    = S_RD_P;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // step to the next header; a wrap is legal only from top to 0
    if (do_adv) begin
      p_nxt = adv_pn;
      if (adv_pn > p_r) begin
        rd_idx    = adv_pn;
        state_nxt = S_CHK_P;
      end else if ((p_r != top_r) || (adv_pn != '0)) begin
        res_data_nxt = '0;
        res_stat_nxt = STAT_OOM;
        state_nxt    = S_DONE;
      end else if (pass_r) begin
        state_nxt = S_GROW_TOP;
      end else begin
        pass_nxt  = 1'b1;
        rd_idx    = adv_pn;
        state_nxt = S_CHK_P;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      search_r <= '0;
      top_r    <= IDX_W'(1);
      brk_r    <= SUM_W'(2);
      sent_r   <= 1'b0;
      pass_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      search_r <= search_nxt;
      top_r    <= top_nxt;
      brk_r    <= brk_nxt;
      sent_r   <= sent_nxt;
      pass_r   <= pass_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r        <= p_nxt;
    cur_next_r <= cur_next_nxt;
    np_r       <= np_nxt;
    gbase_r    <= gbase_nxt;
    nw_r       <= nw_nxt;
    res_data_r <= res_data_nxt;
    res_stat_r <= res_stat_nxt;
  end

  wire out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= res_data_r;
      out_stat_r <= res_stat_r;
    end
  end

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_data_index = out_data_r;
  assign out_status     = out_stat_r;

`ifndef NO_ASSERTIONS
  a_null_free_done: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_req_type == REQ_FREE) && (in_free_index == '0))
      |=> (state_r == S_DONE))
    else $error("null free did not go straight to result");

  a_oom_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_stat_r == STAT_OOM)) |-> (out_data_r == '0))
    else $error("out of memory result carries an index");

  a_brk_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
    (brk_r < SUM_W'(POOL_WORDS)))
    else $error("break count ran past the pool");

  a_grow_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_GROW_BASE) |-> ($past(state_r) == S_GROW_TOP))
    else $error("growth sequence out of order");
`endif

endmodule

@@ sim/cffa_checker.sv @@
`timescale 1ns / 100ps

module cffa_checker
  import cffa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic              in_req_type,
  input  logic [SIZE_W-1:0] in_size_bytes,
  input  logic [IDX_W-1:0]  in_free_index,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [IDX_W-1:0]  out_data_index,
  input  logic              out_status,
  output int                err_count,
  output int                pending,
  output int                n_checked,
  output int                n_oom
);

  localparam int unsigned POOL = 4096;
  localparam int unsigned GROW = 128;
  localparam int unsigned WBYTES = 8;

  typedef struct {
    logic [IDX_W-1:0] data_index;
    cffa_stat_t       status;
  } alloc_result_t;

  // heap image; unwritten entries read as zero
  logic [IDX_W:0] heap_hdr [0:POOL-1];
  int unsigned    rover, top_hdr, brk;
  bit             sentinels_up;
  alloc_result_t  result_q[$];

  function automatic int unsigned hnext(int unsigned i);
    return (i >= POOL) ? 0 : int'(heap_hdr[i][IDX_W:1]);
  endfunction

  function automatic bit hbusy(int unsigned i);
    return (i >= POOL) ? 1'b0 : heap_hdr[i][0];
  endfunction

  function automatic void hset(int unsigned i, int unsigned nxt, bit busy);
    if (i < POOL) heap_hdr[i] = {nxt[IDX_W-1:0], busy};
  endfunction

  function automatic alloc_result_t heap_request(logic rt, logic [SIZE_W-1:0] sz,
                                                 logic [IDX_W-1:0] fi);
    alloc_result_t r;
    int unsigned nw, p, q, nq, np, passes, chunk, base, nb;
    r.data_index = '0;
    r.status = STAT_OK;
    if (cffa_req_t'(rt) == REQ_FREE) begin
      if (fi != 0) begin
        p = fi - 1;
        rover = p;
        hset(p, hnext(p), 1'b0);
      end
      return r;
    end
    if (!sentinels_up) begin
      hset(0, 1, 1'b1);
      hset(1, 0, 1'b1);
      top_hdr = 1;
      rover = 0;
      sentinels_up = 1;
    end
    nw = (sz + 2 * WBYTES - 1) / WBYTES;
    p = rover;
    forever begin
      passes = 0;
      forever begin
        if (!hbusy(p)) begin
          // coalesce following free blocks
          forever begin
            q = hnext(p);
            if (hbusy(q)) break;
            nq = hnext(q);
            if (nq <= q) break;
            hset(p, nq, 1'b0);
            if (q == rover) rover = nq;
          end
          q = hnext(p);
          if (q >= p + nw) begin
            np = p + nw;
            rover = np & 12'hFFF;
            if (q > np) hset(np, hnext(p), 1'b0);
            hset(p, np, 1'b1);
            r.data_index = (p + 1) & 12'hFFF;
            return r;
          end
        end
        q = p;
        p = hnext(p);
        if (p > q) continue;
        if (q != top_hdr || p != 0) begin
          r.status = STAT_OOM;
          return r;
        end
        passes++;
        if (passes > 1) break;
      end
      chunk = ((nw + GROW) / GROW) * GROW;
      base = brk;
      nb = base + chunk;
      if (nb >= POOL) begin
        r.status = STAT_OOM;
        return r;
      end
      brk = nb;
      hset(top_hdr, base, base != top_hdr + 1);
      top_hdr = (base + chunk - 1) & 12'hFFF;
      hset(base, top_hdr, 1'b0);
      hset(top_hdr, 0, 1'b1);
    end
  endfunction

  initial begin
    for (int i = 0; i < POOL; i++) heap_hdr[i] = '0;
    rover = 0;
    top_hdr = 1;
    brk = 2;
    sentinels_up = 0;
    err_count = 0;
    n_checked = 0;
    n_oom = 0;
  end

  assign pending = result_q.size();

  always @(posedge clk) begin
    alloc_result_t exp_r;
    if (rst_n) begin
      if (in_valid && !in_stall)
        result_q.push_back(heap_request(in_req_type, in_size_bytes, in_free_index));
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          $error("unexpected result: data_index %0d status %0d", out_data_index, out_status);
          err_count++;
        end else begin
          exp_r = result_q.pop_front();
          n_checked++;
          if (exp_r.status == STAT_OOM) n_oom++;
          if (out_data_index !== exp_r.data_index) begin
            $error("data_index: expected %0d, actual %0d", exp_r.data_index, out_data_index);
            err_count++;
          end
          if (out_status !== exp_r.status) begin
            $error("status: expected %0d, actual %0d", exp_r.status, out_status);
            err_count++;
          end
        end
      end
    end
  end

endmodule

@@ sim/circular_first_fit_allocator_tb.sv @@
`timescale 1ns / 100ps

module circular_first_fit_allocator_tb;
  import cffa_pkg::*;

  localparam int N_RANDOM = 1700;
  localparam int STALL_LIMIT = 200000;
  localparam int HOLD_CYCLES = 400;

  logic              clk = 0;
  logic              rst_n = 0;
  logic              in_valid = 0;
  logic              in_stall;
  logic              in_req_type = REQ_ALLOC;
  logic [SIZE_W-1:0] in_size_bytes = '0;
  logic [IDX_W-1:0]  in_free_index = '0;
  logic              out_valid;
  logic              out_stall = 0;
  logic [IDX_W-1:0]  out_data_index;
  logic              out_status;

  int err_count, pending, n_checked, n_oom;
  int n_sent = 0, n_alloc = 0, n_free = 0;
  int idle_cycles = 0;
  bit idling = 1;
  logic [IDX_W-1:0] live_blocks[$];

  always #5 clk = ~clk;

  circular_first_fit_allocator u_dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_req_type, .in_size_bytes, .in_free_index,
    .out_valid, .out_stall, .out_data_index, .out_status
  );

  cffa_checker u_chk (
    .clk, .rst_n, .in_valid, .in_stall, .in_req_type, .in_size_bytes, .in_free_index,
    .out_valid, .out_stall, .out_data_index, .out_status,
    .err_count, .pending, .n_checked, .n_oom
  );

  // remember returned blocks; sampled mid-cycle so the stimulus side sees them cleanly
  always @(negedge clk)
    if (out_valid && !out_stall && out_status == STAT_OK && out_data_index != 0)
      live_blocks.push_back(out_data_index);

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver: random stall bursts, plus one long hold-off while input keeps coming
  initial begin
    int n_taken;
    bit held;
    n_taken = 0;
    held = 0;
    @(posedge clk iff rst_n);
    forever begin
      if (!held && n_taken >= 200) begin
        held = 1;
        out_stall <= 1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= 0;
      repeat ($urandom_range(1, 10)) begin
        @(posedge clk);
        if (out_valid) n_taken++;
      end
      if (idling && $urandom_range(0, 2) == 0) begin
        out_stall <= 1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
  end

  task automatic send(cffa_req_t rt, int unsigned sz, int unsigned fi);
    in_valid <= 1;
    in_req_type <= rt;
    in_size_bytes <= sz[SIZE_W-1:0];
    in_free_index <= fi[IDX_W-1:0];
    do @(posedge clk); while (in_stall);
    n_sent++;
    if (rt == REQ_FREE) n_free++; else n_alloc++;
    if (idling && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic free_live(bit keep);
    int k;
    logic [IDX_W-1:0] blk;
    k = $urandom_range(0, live_blocks.size() - 1);
    blk = live_blocks[k];
    if (!keep) live_blocks.delete(k);
    send(REQ_FREE, 0, blk);
  endtask

  initial begin
    int r, sz;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: null free before anything exists, size corners, sentinel frees
    send(REQ_FREE, 0, 0);
    send(REQ_ALLOC, 0, 0);
    send(REQ_ALLOC, 1, 0);
    send(REQ_ALLOC, 8, 0);
    send(REQ_ALLOC, 9, 0);
    send(REQ_ALLOC, 16, 0);
    send(REQ_ALLOC, 17, 0);
    send(REQ_ALLOC, 32767, 0);
    send(REQ_ALLOC, 20000, 0);
    send(REQ_ALLOC, 3000, 0);
    send(REQ_ALLOC, 1000, 0);
    while (live_blocks.size() < 7) @(posedge clk);
    free_live(0);
    free_live(0);
    send(REQ_ALLOC, 24, 0);
    free_live(1);
    free_live(1);           // may free the kept block again
    send(REQ_FREE, 0, 1);   // low sentinel
    send(REQ_ALLOC, 0, 0);
    send(REQ_FREE, 0, 2);   // high sentinel
    send(REQ_ALLOC, 5000, 0);
    send(REQ_ALLOC, 12000, 0);
    send(REQ_FREE, 0, 0);

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM - 200) idling = 0;
      r = $urandom_range(0, 99);
      if (r < 5) begin
        send(REQ_FREE, $urandom, 0);
      end else if (r < 42 && live_blocks.size() > 0) begin
        free_live($urandom_range(0, 9) == 0);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 85) sz = $urandom_range(0, 255);
        else if (r < 95) sz = $urandom_range(256, 2047);
        else sz = $urandom_range(0, 32767);
        send(REQ_ALLOC, sz, $urandom);
      end
    end
    in_valid <= 0;

    // let the checker take in the last item before watching the backlog
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Sent %0d requests (%0d allocate, %0d free); %0d results checked, %0d out of memory.",
             n_sent, n_alloc, n_free, n_checked, n_oom);
    if (err_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ filelist.f @@
src/cffa_pkg.sv
src/cffa_hdr_ram.sv
src/circular_first_fit_allocator.sv
sim/cffa_checker.sv
sim/circular_first_fit_allocator_tb.sv
